### hdl/cbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants for the cubic Bezier flattener.
// ----------------------------------------------------------------------------
package cbf_pkg;
  localparam int unsigned CoordBits   = 24;
  localparam int unsigned MaxSegments = 64;
  localparam int unsigned CfgBits     = 16;
  localparam int unsigned OneQ16      = 65536;
  localparam int unsigned MinDt       = (OneQ16 + MaxSegments - 1) / MaxSegments;
  localparam logic [17:0] Sqrt8Q16    = 18'd185364;

  typedef enum logic {
    CFG_ZOOM      = 1'b0,
    CFG_TOLERANCE = 1'b1
  } cfg_idx_e;

  typedef logic signed [CoordBits-1:0] coord_t;

  typedef struct packed {
    coord_t x0; coord_t y0;
    coord_t x1; coord_t y1;
    coord_t x2; coord_t y2;
    coord_t x3; coord_t y3;
  } curve_t;

  typedef struct packed {
    coord_t from_x;
    coord_t from_y;
    coord_t to_x;
    coord_t to_y;
    logic   final_segment;
  } seg_t;

  // Control between sequencer and evaluation pipeline.
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [16:0] t;
  } step_t;
endpackage

### hdl/cbf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_curve_if / cbf_seg_if
// Valid/ready channels for curves and segments.
// ----------------------------------------------------------------------------
interface cbf_curve_if;
  import cbf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y;
  modport source (output valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                  end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y,
                end_x, end_y, output ready);
endinterface

interface cbf_seg_if;
  import cbf_pkg::*;
  logic   valid;
  logic   ready;
  coord_t seg_from_x, seg_from_y, seg_to_x, seg_to_y;
  logic   final_segment;
  modport source (output valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y,
                  final_segment, input ready);
  modport sink (input valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y,
                final_segment, output ready);
endinterface

### hdl/cbf_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_step
// Step size: curvature bound, integer square roots and division, one bit a
// cycle, then clamping of dt.
// ----------------------------------------------------------------------------
module cbf_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  cbf_pkg::curve_t          curve_i,
  input  logic [cbf_pkg::CfgBits-1:0] zoom_i,
  input  logic [cbf_pkg::CfgBits-1:0] tol_i,
  output logic                     done_o,
  output logic [16:0]              dt_o
);
  import cbf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQ   = 7'b0000010,
    S_MAX  = 7'b0000100,
    S_RT1  = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_RT2  = 7'b1000000
  } state_e;

  localparam int unsigned DW = CoordBits + 5;

  state_e            state_q, state_d;
  logic signed [DW-1:0] bx_q, by_q, cx_q, cy_q;
  logic [63:0]       s1_q, s2_q, rad_q, rem_q;
  logic [31:0]       root_q;
  logic [5:0]        cnt_q;
  logic [63:0]       num_q, den_q;
  logic [64:0]       quo_q;
  logic [16:0]       dt_q;
  logic              done_q;

  logic signed [DW-1:0] ax, ay, bxw, byw;
  logic [DW-1:0] mbx, mby, mcx, mcy;
  logic [65:0] trial;
  logic [64:0] drem;
  logic [47:0] den_w;

  always_comb begin
    ax  = DW'(-DW'(curve_i.x0) + 3 * DW'(curve_i.x1) - 3 * DW'(curve_i.x2)
              + DW'(curve_i.x3));
    ay  = DW'(-DW'(curve_i.y0) + 3 * DW'(curve_i.y1) - 3 * DW'(curve_i.y2)
              + DW'(curve_i.y3));
    bxw = DW'(3 * (DW'(curve_i.x0) - 2 * DW'(curve_i.x1) + DW'(curve_i.x2)));
    byw = DW'(3 * (DW'(curve_i.y0) - 2 * DW'(curve_i.y1) + DW'(curve_i.y2)));
    mbx = bx_q[DW-1] ? DW'(-bx_q) : DW'(bx_q);
    mby = by_q[DW-1] ? DW'(-by_q) : DW'(by_q);
    mcx = cx_q[DW-1] ? DW'(-cx_q) : DW'(cx_q);
    mcy = cy_q[DW-1] ? DW'(-cy_q) : DW'(cy_q);
    // restoring square root: two radicand bits per cycle
    trial = {rem_q[63:0], rad_q[63:62]} - {32'd0, root_q, 2'b01};
    drem  = {quo_q[63:0], rem_q[63]};
    den_w = 48'(zoom_i) * 48'(root_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (start_i) state_d = S_SQ;
      S_SQ:   state_d = S_MAX;
      S_MAX:  state_d = S_RT1;
      S_RT1:  if (cnt_q == 6'd31) state_d = S_MUL;
      S_MUL:  state_d = (den_w == 48'd0) ? S_IDLE : S_DIV;
      S_DIV:  if (cnt_q == 6'd63) state_d = S_RT2;
      S_RT2:  if (cnt_q == 6'd31) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= ((state_q == S_MUL) && (den_w == 48'd0)) ||
                 ((state_q == S_RT2) && (cnt_q == 6'd31));
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        bx_q <= bxw; by_q <= byw; cx_q <= ax + bxw; cy_q <= ay + byw;
        num_q <= 64'(Sqrt8Q16 * tol_i) << 24;
      end
      S_SQ: begin
        s1_q <= 64'(mbx * mbx) + 64'(mby * mby);
        s2_q <= 64'(mcx * mcx) + 64'(mcy * mcy);
      end
      S_MAX: begin
        rad_q  <= (s1_q > s2_q) ? s1_q : s2_q;
        rem_q  <= '0; root_q <= '0; cnt_q <= '0;
      end
      S_RT1, S_RT2: begin
        cnt_q <= cnt_q + 6'd1;
        rad_q <= {rad_q[61:0], 2'b00};
        if (!trial[65]) begin
          rem_q <= trial[63:0]; root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q <= {rem_q[61:0], rad_q[63:62]}; root_q <= {root_q[30:0], 1'b0};
        end
        if (state_q == S_RT2 && cnt_q == 6'd31) begin
          if (quo_q[63:32] != 32'd0) dt_q <= 17'(OneQ16);
          else if ({root_q[30:0], !trial[65]} < 32'(MinDt)) dt_q <= 17'(MinDt);
          else if ({root_q[30:0], !trial[65]} > 32'(OneQ16)) dt_q <= 17'(OneQ16);
          else dt_q <= {root_q[15:0], !trial[65]};
        end
      end
      S_MUL: begin
        den_q <= 64'(den_w);
        quo_q <= '0; cnt_q <= '0; rem_q <= num_q;
        dt_q  <= 17'(OneQ16);
      end
      S_DIV: begin
        // rem_q shifts dividend bits; quo_q holds the partial remainder
        if (cnt_q == 6'd63) begin
          // quotient lands in rad_q; flag large quotients through quo_q top
          quo_q <= {1'b0, (rad_q[62:31] != 32'd0) ? 32'd1 : 32'd0, 32'd0};
          rad_q <= {rad_q[62:0], (drem >= {1'b0, den_q})};
          rem_q <= '0; root_q <= '0; cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + 6'd1;
          rem_q <= {rem_q[62:0], 1'b0};
          if (drem >= {1'b0, den_q}) begin
            quo_q <= 65'(drem - {1'b0, den_q});
            rad_q <= {rad_q[62:0], 1'b1};
          end else begin
            quo_q <= drem;
            rad_q <= {rad_q[62:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign dt_o   = dt_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> dt_q >= 17'(MinDt))
    else $error("dt below clamp");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> dt_q <= 17'(OneQ16))
    else $error("dt above one");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> $past(state_q) != S_IDLE)
    else $error("done without work");
endmodule

### hdl/cbf_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_eval
// Four-stage de Casteljau pipeline for both axes, with stall support.
// ----------------------------------------------------------------------------
module cbf_eval (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  cbf_pkg::step_t  step_i,
  input  cbf_pkg::curve_t curve_i,
  output cbf_pkg::step_t  step_o,
  output cbf_pkg::coord_t x_o,
  output cbf_pkg::coord_t y_o
);
  import cbf_pkg::*;

  localparam int unsigned W = CoordBits + 1;

  function automatic coord_t lerp(coord_t u, coord_t v, logic [16:0] t);
    logic signed [W+17:0] d;
    d = (W'(v) - W'(u)) * $signed({1'b0, t});
    return coord_t'(W'(u) + W'(d >>> 16));
  endfunction

  step_t  st_q [4];
  coord_t c_q  [4][8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) st_q[i] <= '0;
    end else if (adv_i) begin
      st_q[0] <= step_i;
      for (int i = 1; i < 4; i++) st_q[i] <= st_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      c_q[0][0] <= curve_i.x0; c_q[0][1] <= curve_i.x1;
      c_q[0][2] <= curve_i.x2; c_q[0][3] <= curve_i.x3;
      c_q[0][4] <= curve_i.y0; c_q[0][5] <= curve_i.y1;
      c_q[0][6] <= curve_i.y2; c_q[0][7] <= curve_i.y3;
      for (int a = 0; a < 2; a++) begin
        c_q[1][4*a]   <= lerp(c_q[0][4*a],   c_q[0][4*a+1], st_q[0].t);
        c_q[1][4*a+1] <= lerp(c_q[0][4*a+1], c_q[0][4*a+2], st_q[0].t);
        c_q[1][4*a+2] <= lerp(c_q[0][4*a+2], c_q[0][4*a+3], st_q[0].t);
        c_q[1][4*a+3] <= '0;
        c_q[2][4*a]   <= lerp(c_q[1][4*a],   c_q[1][4*a+1], st_q[1].t);
        c_q[2][4*a+1] <= lerp(c_q[1][4*a+1], c_q[1][4*a+2], st_q[1].t);
        c_q[2][4*a+2] <= '0;
        c_q[2][4*a+3] <= '0;
        c_q[3][4*a]   <= lerp(c_q[2][4*a],   c_q[2][4*a+1], st_q[2].t);
        for (int k = 1; k < 4; k++) c_q[3][4*a+k] <= '0;
      end
    end
  end

  assign step_o = st_q[3];
  assign x_o    = c_q[3][0];
  assign y_o    = c_q[3][4];

  assert property (@(posedge clk_i) disable iff (!rst_ni) !adv_i |=> $stable(st_q[3]))
    else $error("stage moved during stall");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q[3].valid && st_q[3].last |-> st_q[3].t == 17'(OneQ16))
    else $error("last step not at one");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && st_q[2].valid |=> st_q[3].valid)
    else $error("valid lost");
endmodule

### hdl/cubic_bezier_flattener.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Adaptive cubic Bezier flattening into line segments.
//
//   channel   dir  payload
//   curve     in   start/ctrl1/ctrl2/end x,y (Q16.8)
//   seg       out  seg_from/seg_to x,y, final_segment
//   cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i
//
// Step setup finds dt through two 32-step square roots and a 64-step
// division, stopping after the first root with dt at one when zoom or the
// curvature bound is zero. Segments pass through the 4-stage pipeline into
// the output register, one per cycle while the output is not stalled. Curves
// are handled one at a time; the next is taken the cycle after the last
// segment of the previous one reaches the output register. Reset clears all
// control state; stalls on the output freeze the pipeline.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_idx_i,
  input  logic [cbf_pkg::CfgBits-1:0] cfg_data_i,
  cbf_curve_if.sink                  curve_i,
  cbf_seg_if.source                  seg_o
);
  import cbf_pkg::*;

  logic [CfgBits-1:0] zoom_q, tol_q;
  logic      busy_q, run_q, issued_last_q;
  curve_t    curve_q;
  logic [16:0] dt_q, t_q;
  logic        step_done;
  logic [16:0] dt;
  step_t       step_in, step_out;
  coord_t      ex, ey, px_q, py_q;
  logic        out_v_q, adv;
  seg_t        out_q;
  logic [17:0] t_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q <= 16'd256;
      tol_q  <= 16'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ZOOM:      zoom_q <= cfg_data_i;
        CFG_TOLERANCE: tol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign curve_i.ready = !busy_q;

  cbf_step u_step (
    .clk_i, .rst_ni,
    .start_i (curve_i.valid && !busy_q),
    .curve_i ('{curve_i.start_x, curve_i.start_y, curve_i.ctrl1_x, curve_i.ctrl1_y,
                curve_i.ctrl2_x, curve_i.ctrl2_y, curve_i.end_x, curve_i.end_y}),
    .zoom_i  (zoom_q), .tol_i (tol_q),
    .done_o  (step_done), .dt_o (dt)
  );

  assign adv   = !out_v_q || seg_o.ready;
  assign t_sum = 18'(t_q) + 18'(dt_q);
  always_comb begin
    step_in.valid = run_q && !issued_last_q;
    step_in.t     = (t_sum >= 18'(OneQ16)) ? 17'(OneQ16) : t_sum[16:0];
    step_in.last  = (t_sum >= 18'(OneQ16));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; run_q <= 1'b0; issued_last_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (curve_i.valid && !busy_q) busy_q <= 1'b1;
      if (step_done) begin
        run_q <= 1'b1; issued_last_q <= 1'b0;
      end else if (adv && step_in.valid && step_in.last) begin
        issued_last_q <= 1'b1;
      end
      if (adv) out_v_q <= step_out.valid;
      if (adv && step_out.valid && step_out.last) begin
        run_q <= 1'b0; busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (curve_i.valid && !busy_q) begin
      curve_q <= '{curve_i.start_x, curve_i.start_y, curve_i.ctrl1_x, curve_i.ctrl1_y,
                   curve_i.ctrl2_x, curve_i.ctrl2_y, curve_i.end_x, curve_i.end_y};
      px_q <= curve_i.start_x; py_q <= curve_i.start_y;
    end
    if (step_done) begin
      dt_q <= dt; t_q <= '0;
    end else if (adv && step_in.valid) begin
      t_q <= step_in.t;
    end
    if (adv && step_out.valid) begin
      out_q <= '{px_q, py_q, ex, ey, step_out.last};
      px_q  <= ex; py_q <= ey;
    end
  end

  cbf_eval u_eval (
    .clk_i, .rst_ni, .adv_i (adv), .step_i (step_in), .curve_i (curve_q),
    .step_o (step_out), .x_o (ex), .y_o (ey)
  );

  assign seg_o.valid         = out_v_q;
  assign seg_o.seg_from_x    = out_q.from_x;
  assign seg_o.seg_from_y    = out_q.from_y;
  assign seg_o.seg_to_x      = out_q.to_x;
  assign seg_o.seg_to_y      = out_q.to_y;
  assign seg_o.final_segment = out_q.final_segment;

  assert property (@(posedge clk_i) disable iff (!rst_ni) run_q |-> busy_q)
    else $error("running without a curve");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid && !seg_o.ready |=> seg_o.valid)
    else $error("transaction dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni) step_done |-> busy_q && !run_q)
    else $error("step result out of turn");
endmodule
